FILE: design/hnm_pkg.sv
// ----------------------------------------------------------------------------
// hnm_pkg
// Shared types and constants of the height to normal map block.
// ----------------------------------------------------------------------------
package hnm_pkg;

  localparam int COL_W   = 10;
  localparam int ROW_W   = 12;
  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 16;
  localparam int IWID_W  = 11;
  localparam int T_W     = 34;
  localparam int NT_W    = 41;
  localparam int P_W     = 48;
  localparam int NBITS   = 7;

  // line store depth; tied to COL_W and IWID_W
  localparam int MAX_WIDTH = 1024;

  localparam logic REG_IMAGE_WIDTH   = 1'b0;
  localparam logic REG_INVERSE_SCALE = 1'b1;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [BYTE_W-1:0] alpha;
  } meta_t;

  typedef struct packed {
    logic [NBITS-1:0] n;
    logic [NT_W-1:0]  nt;
    logic [P_W-1:0]   nnt;
    logic [P_W-1:0]   lim;
    logic             neg;
  } lane_t;

  // x * 16129 = x*16384 - x*256 + x
  function automatic logic [P_W-1:0] mul_16129(input logic [P_W-1:0] x);
    mul_16129 = (x << 14) - (x << 8) + x;
  endfunction

endpackage

FILE: design/hnm_in_if.sv
// ----------------------------------------------------------------------------
// hnm_in_if
// Input word channel: pixel position with height and specular bytes.
// ----------------------------------------------------------------------------
interface hnm_in_if import hnm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  pixel_col;
  logic [ROW_W-1:0]  pixel_row;
  logic [BYTE_W-1:0] height_sample;
  logic [BYTE_W-1:0] specular_sample;

  modport source (output valid, pixel_col, pixel_row, height_sample, specular_sample,
                  input ready);
  modport sink   (input valid, pixel_col, pixel_row, height_sample, specular_sample,
                  output ready);
endinterface

FILE: design/hnm_out_if.sv
// ----------------------------------------------------------------------------
// hnm_out_if
// Output word channel: normal map pixel with position and alpha.
// ----------------------------------------------------------------------------
interface hnm_out_if import hnm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  out_col;
  logic [ROW_W-1:0]  out_row;
  logic [BYTE_W-1:0] normal_x;
  logic [BYTE_W-1:0] normal_y;
  logic [BYTE_W-1:0] normal_z;
  logic [BYTE_W-1:0] alpha_spec;

  modport source (output valid, out_col, out_row, normal_x, normal_y, normal_z, alpha_spec,
                  input ready);
  modport sink   (input valid, out_col, out_row, normal_x, normal_y, normal_z, alpha_spec,
                  output ready);
endinterface

FILE: design/height_to_normal_map.sv
// One pixel per cycle sustained while the output register is not stalled.
// Line store reads and writes at acceptance; a 7-stage bit search resolves each component.
// A stalled output register stalls the whole pipeline; in_s.ready follows it directly.
// Reset (rst_n, synchronous) clears valids and loads image_width 256, inverse_scale 2560.
// Line store contents are undefined until each column has been written once.
// ----------------------------------------------------------------------------
// height_to_normal_map
// Streaming height map to normal map conversion with a previous-row line store.
// ----------------------------------------------------------------------------
module height_to_normal_map import hnm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  hnm_in_if.sink           in_s,
  hnm_out_if.source        out_m,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int NS = NBITS;

  logic [IWID_W-1:0] width_r;
  logic [CFG_W-1:0]  scale_r;
  logic [IWID_W-1:0] wcap;
  logic              adv;
  logic              acc;
  logic              in_range;
  logic              emit;

  // stage 1
  logic              v1_r;
  meta_t             m1_r;
  logic [BYTE_W-1:0] h1_r;
  logic [15:0]       up_q;
  logic [15:0]       ur_q;
  // stage 2
  logic              v2_r;
  meta_t             m2_r;
  logic signed [8:0] dx_r;
  logic signed [8:0] dy_r;
  // stage 3
  logic              v3_r;
  meta_t             m3_r;
  logic [31:0]       r2_r;
  logic [15:0]       dx2_r;
  logic [15:0]       dy2_r;
  logic              negx_r;
  logic              negy_r;
  // search stages
  logic              vs_r [NS+1];
  meta_t             ms_r [NS+1];
  logic [T_W-1:0]    ts_r [NS+1];
  logic              zs_r [NS+1];
  lane_t             ln_r [NS+1][3];
  lane_t             ln_nxt [NS][3];
  // output
  logic              ov_r;
  meta_t             om_r;
  logic [BYTE_W-1:0] nx_r;
  logic [BYTE_W-1:0] ny_r;
  logic [BYTE_W-1:0] nz_r;

  logic [P_W-1:0]    t_nxt;
  logic [P_W-1:0]    numx;
  logic [P_W-1:0]    numy;
  logic [P_W-1:0]    numz;
  logic [BYTE_W-1:0] comp [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= IWID_W'(256);
      scale_r <= CFG_W'(2560);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   width_r <= cfg_wdata[IWID_W-1:0];
        REG_INVERSE_SCALE: scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign wcap     = (32'(width_r) > MAX_WIDTH) ? IWID_W'(MAX_WIDTH) : width_r;
  assign adv      = !ov_r || out_m.ready;
  assign in_s.ready = adv;
  assign acc      = in_s.valid && adv;
  assign in_range = {1'b0, in_s.pixel_col} < wcap;
  assign emit     = in_range && (in_s.pixel_row != '0) &&
                    (({1'b0, in_s.pixel_col} + IWID_W'(1)) < wcap);

  hnm_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_ram_up (
    .clk   (clk),
    .we    (acc && in_range),
    .waddr (AW'(in_s.pixel_col)),
    .wdata ({in_s.specular_sample, in_s.height_sample}),
    .re    (adv),
    .raddr (AW'(in_s.pixel_col)),
    .rdata (up_q)
  );

  hnm_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_ram_ur (
    .clk   (clk),
    .we    (acc && in_range),
    .waddr (AW'(in_s.pixel_col)),
    .wdata ({in_s.specular_sample, in_s.height_sample}),
    .re    (adv),
    .raddr (AW'({1'b0, in_s.pixel_col} + IWID_W'(1))),
    .rdata (ur_q)
  );

  assign t_nxt = 48'(r2_r) + ((48'(dx2_r) + 48'(dy2_r)) << 16);
  assign numx  = mul_16129(48'(dy2_r)) << 16;
  assign numy  = mul_16129(48'(dx2_r)) << 16;
  assign numz  = mul_16129(48'(r2_r));

  always_comb begin
    int b;
    logic [P_W-1:0] t48;
    logic [NT_W-1:0] cnt;
    logic [P_W-1:0] cnn;
    for (int s = 0; s < NS; s++) begin
      for (int l = 0; l < 3; l++) begin
        b   = NS - 1 - s;
        t48 = P_W'(ts_r[s]);
        cnt = ln_r[s][l].nt + NT_W'(t48 << b);
        cnn = ln_r[s][l].nnt + (P_W'(ln_r[s][l].nt) << (b + 1)) + (t48 << (2 * b));
        ln_nxt[s][l] = ln_r[s][l];
        if (cnn <= ln_r[s][l].lim) begin
          ln_nxt[s][l].n   = ln_r[s][l].n | NBITS'(1 << b);
          ln_nxt[s][l].nt  = cnt;
          ln_nxt[s][l].nnt = cnn;
        end
      end
    end
  end

  always_comb begin
    logic [BYTE_W-1:0] p;
    for (int l = 0; l < 3; l++) begin
      p = BYTE_W'(128) + BYTE_W'(ln_r[NS][l].n);
      if (zs_r[NS]) begin
        comp[l] = BYTE_W'(128);
      end else if (ln_r[NS][l].neg) begin
        comp[l] = ~p;
      end else begin
        comp[l] = p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
      for (int s = 0; s <= NS; s++) begin
        vs_r[s] <= 1'b0;
      end
    end else if (adv) begin
      v1_r <= acc && emit;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vs_r[0] <= v3_r;
      for (int s = 0; s < NS; s++) begin
        vs_r[s+1] <= vs_r[s];
      end
      ov_r <= vs_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r.col   <= in_s.pixel_col;
      m1_r.row   <= in_s.pixel_row - ROW_W'(1);
      m1_r.alpha <= '0;
      h1_r       <= in_s.height_sample;

      m2_r       <= '{col: m1_r.col, row: m1_r.row, alpha: up_q[15:8]};
      dx_r       <= $signed({1'b0, ur_q[7:0]}) - $signed({1'b0, up_q[7:0]});
      dy_r       <= $signed({1'b0, h1_r}) - $signed({1'b0, up_q[7:0]});

      m3_r   <= m2_r;
      r2_r   <= 32'(scale_r) * 32'(scale_r);
      dx2_r  <= 16'(dx_r * dx_r);
      dy2_r  <= 16'(dy_r * dy_r);
      negx_r <= dy_r > 0;
      negy_r <= dx_r < 0;

      ms_r[0] <= m3_r;
      ts_r[0] <= T_W'(t_nxt);
      zs_r[0] <= t_nxt == '0;
      ln_r[0][0] <= '{n: '0, nt: '0, nnt: '0, lim: numx - P_W'(negx_r), neg: negx_r};
      ln_r[0][1] <= '{n: '0, nt: '0, nnt: '0, lim: numy - P_W'(negy_r), neg: negy_r};
      ln_r[0][2] <= '{n: '0, nt: '0, nnt: '0, lim: numz, neg: 1'b0};

      for (int s = 0; s < NS; s++) begin
        ms_r[s+1] <= ms_r[s];
        ts_r[s+1] <= ts_r[s];
        zs_r[s+1] <= zs_r[s];
        for (int l = 0; l < 3; l++) begin
          ln_r[s+1][l] <= ln_nxt[s][l];
        end
      end

      om_r <= ms_r[NS];
      nx_r <= comp[0];
      ny_r <= comp[1];
      nz_r <= comp[2];
    end
  end

  assign out_m.valid      = ov_r;
  assign out_m.out_col    = om_r.col;
  assign out_m.out_row    = om_r.row;
  assign out_m.normal_x   = nx_r;
  assign out_m.normal_y   = ny_r;
  assign out_m.normal_z   = nz_r;
  assign out_m.alpha_spec = om_r.alpha;

`ifndef SYNTHESIS
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (nx_r != '0) && (ny_r != '0) && (nz_r != '0))
    else $error("normal component of zero");

  a_z_up: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> nz_r[BYTE_W-1])
    else $error("normal_z below bias");

  a_not_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> ({1'b0, om_r.col} + IWID_W'(1)) < IWID_W'(MAX_WIDTH))
    else $error("last column emitted");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vs_r[NS]) && $stable(v1_r))
    else $error("pipeline moved during stall");
`endif

endmodule

FILE: design/hnm_ram.sv
// ----------------------------------------------------------------------------
// hnm_ram
// Generic single write, single read RAM; registered read, old data on collision.
// ----------------------------------------------------------------------------
module hnm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: tb/tb_height_to_normal_map.sv
// ----------------------------------------------------------------------------
// tb_height_to_normal_map
// Streams raster frames of height and specular bytes into the block under
// several width and scale settings, predicts each normal map word with an
// exact integer search and compares every output word field by field.
// ----------------------------------------------------------------------------
module tb_height_to_normal_map;
  import hnm_pkg::*;

  localparam int MAXW       = 1024;
  localparam int DRAIN_CYC  = 24;
  localparam int CYCLE_CAP  = 400000;
  localparam int ITEM_GOAL  = 1800;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [BYTE_W-1:0] h;
    logic [BYTE_W-1:0] s;
  } pix_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [BYTE_W-1:0] nx;
    logic [BYTE_W-1:0] ny;
    logic [BYTE_W-1:0] nz;
    logic [BYTE_W-1:0] al;
  } normal_px_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  hnm_in_if  in_ch();
  hnm_out_if out_ch();

  height_to_normal_map i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_s     (in_ch),
    .out_m    (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [15:0]  line_mirror [MAXW];
  bit           col_written [MAXW];
  int unsigned  cur_width;
  int unsigned  cur_scale;
  normal_px_t   normal_q[$];

  int  errors;
  int  words_sent;
  int  words_checked;
  int  cfg_writes;
  int  cycles;
  bit  calm;
  int  hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [7:0] biased(longint a, longint unsigned t);
    longint unsigned mag;
    longint unsigned num;
    longint unsigned c;
    int n;
    mag = (a < 0) ? longint'(-a) : longint'(a);
    num = 64'd16129 * mag * mag;
    if (a >= 0) begin
      n = 0;
      for (c = 1; c <= 127; c++)
        if (c * c * t <= num) n = int'(c);
      return 8'(128 + n);
    end
    n = 127;
    for (c = 127; c > 0; c--)
      if (c * c * t >= num) n = int'(c);
    return 8'(128 - n);
  endfunction

  function automatic int unsigned eff_width();
    return (cur_width > MAXW) ? MAXW : cur_width;
  endfunction

  task automatic predict_normal(input pix_t p);
    int unsigned w;
    longint hup, dx, dy;
    longint unsigned t;
    normal_px_t e;
    w = eff_width();
    if (p.col >= w) return;
    if (p.row > 0 && p.col + 1 < w) begin
      hup = line_mirror[p.col][7:0];
      dx  = longint'(line_mirror[p.col + 1][7:0]) - hup;
      dy  = longint'(p.h) - hup;
      t   = longint'(cur_scale) * cur_scale + 64'd65536 * longint'(dx * dx + dy * dy);
      e.col = p.col;
      e.row = p.row - 1'b1;
      e.al  = line_mirror[p.col][15:8];
      if (t == 0) begin
        e.nx = 8'd128; e.ny = 8'd128; e.nz = 8'd128;
      end else begin
        e.nx = biased(-256 * dy, t);
        e.ny = biased(256 * dx, t);
        e.nz = biased(longint'(cur_scale), t);
      end
      normal_q.push_back(e);
    end
    line_mirror[p.col] = {p.s, p.h};
    col_written[p.col] = 1'b1;
  endtask

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(input pix_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.pixel_col       <= p.col;
    in_ch.pixel_row       <= p.row;
    in_ch.height_sample   <= p.h;
    in_ch.specular_sample <= p.s;
    do @(posedge clk); while (!in_ch.ready);
    predict_normal(p);
    if (p.col < eff_width()) words_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (normal_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) cur_width = val & 11'h7FF;
    else cur_scale = val & 16'hFFFF;
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic set_mode(input int unsigned w, input int unsigned sc);
    drain();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_INVERSE_SCALE, sc);
  endtask

  function automatic pix_t mk(int c, int r, int h, int s);
    pix_t p;
    p.col = COL_W'(c); p.row = ROW_W'(r); p.h = BYTE_W'(h); p.s = BYTE_W'(s);
    return p;
  endfunction

  function automatic bit frame_ready(int unsigned w);
    for (int c = 0; c < w; c++)
      if (!col_written[c]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic send_frame(input int rows);
    int unsigned w;
    int r0, base, hv;
    w = eff_width();
    r0 = frame_ready(w) ? $urandom_range(0, 4095 - rows) : 0;
    base = $urandom_range(0, 255);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < w; c++) begin
        hv = $urandom_range(0, 1) ? $urandom_range(0, 255) : (base ^ $urandom_range(0, 3));
        send_word(mk(c, r0 + r, hv, $urandom_range(0, 255)));
      end
  endtask

  // out-of-range column, or an in-range word that never reads an unwritten entry
  task automatic send_noise();
    int unsigned w;
    int c, r;
    w = eff_width();
    if (w >= MAXW || $urandom_range(0, 1)) begin
      c = (w == 0) ? $urandom_range(0, 1023) : $urandom_range(0, w - 1);
      r = $urandom_range(0, 4095);
      if (c + 1 < w && !(col_written[c] && col_written[c + 1])) r = 0;
    end else begin
      c = $urandom_range(w, 1023);
      r = $urandom_range(0, 4095);
    end
    send_word(mk(c, r, $urandom_range(0, 255), $urandom_range(0, 255)));
  endtask

  // receiver side: random ready with long hold-offs on request
  initial begin
    int run_left;
    int hold_left;
    bit rdy;
    run_left = 0;
    hold_left = 0;
    rdy = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin rdy = 1'b1; run_left = $urandom_range(1, 8); end
            5, 6, 7:       begin rdy = 1'b0; run_left = $urandom_range(1, 3); end
            8:             begin rdy = 1'b1; run_left = $urandom_range(40, 120); end
            default:       begin rdy = 1'b0; run_left = $urandom_range(10, 40); end
          endcase
        end
        run_left--;
        out_ch.ready <= rdy;
      end
    end
  end

  always @(posedge clk) begin
    normal_px_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (normal_q.size() == 0) begin
        $display("%0t: unexpected word col=%0d row=%0d", $time, out_ch.out_col, out_ch.out_row);
        errors++;
      end else begin
        e = normal_q.pop_front();
        words_checked++;
        if ({out_ch.out_col, out_ch.out_row, out_ch.normal_x, out_ch.normal_y,
             out_ch.normal_z, out_ch.alpha_spec} !== e) begin
          $display("%0t: mismatch exp col=%0d row=%0d n=%0d/%0d/%0d a=%0d", $time,
                   e.col, e.row, e.nx, e.ny, e.nz, e.al);
          $display("%0t:          got col=%0d row=%0d n=%0d/%0d/%0d a=%0d", $time,
                   out_ch.out_col, out_ch.out_row, out_ch.normal_x, out_ch.normal_y,
                   out_ch.normal_z, out_ch.alpha_spec);
          errors++;
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_word(mk(0, 0, 10, 1));
    send_word(mk(1, 0, 200, 2));
    send_word(mk(2, 0, 255, 3));
    send_word(mk(255, 0, 7, 4));
    send_word(mk(0, 1, 0, 5));
    send_word(mk(1, 1, 255, 6));
    send_word(mk(255, 1, 9, 7));
    send_word(mk(256, 3, 9, 8));
  endtask

  task automatic test_extremes();
    set_mode(1024, 65535);
    send_word(mk(1022, 0, 0, 255));
    send_word(mk(1023, 0, 255, 0));
    send_word(mk(1022, 4095, 255, 0));
    send_word(mk(1023, 4095, 0, 255));
    set_mode(2047, 1);
    send_word(mk(1022, 7, 0, 0));
    send_word(mk(1023, 7, 255, 255));
    send_word(mk(1022, 8, 255, 17));
    set_mode(0, 256);
    send_word(mk(0, 5, 1, 1));
    send_word(mk(1023, 5, 1, 1));
    set_mode(1, 256);
    send_word(mk(0, 0, 50, 60));
    send_word(mk(0, 9, 51, 61));
    send_word(mk(5, 9, 51, 61));
  endtask

  task automatic test_zero_norm();
    set_mode(3, 0);
    send_word(mk(0, 0, 80, 11));
    send_word(mk(1, 0, 80, 12));
    send_word(mk(2, 0, 80, 13));
    send_word(mk(0, 1, 80, 14));
    send_word(mk(1, 1, 81, 15));
    send_word(mk(0, 2, 80, 16));
  endtask

  task automatic test_backpressure();
    set_mode(8, 3000);
    calm = 1'b1;
    hold_req = 300;
    send_frame(8);
    drain();
    calm = 1'b0;
    send_frame(3);
    drain();
    send_frame(3);
  endtask

  task automatic test_random_frames();
    int unsigned w;
    int unsigned sc;
    while (words_sent < ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 1);
        1:       w = 2;
        default: w = $urandom_range(3, 14);
      endcase
      case ($urandom_range(0, 5))
        0:       sc = 0;
        1:       sc = 65535;
        2:       sc = $urandom_range(1, 64);
        default: sc = $urandom_range(0, 65535);
      endcase
      set_mode(w, sc);
      calm = ($urandom_range(0, 4) == 0);
      send_frame($urandom_range(2, 6));
      repeat ($urandom_range(0, 6)) send_noise();
    end
    calm = 1'b0;
  endtask

  initial begin
    errors = 0; words_sent = 0; words_checked = 0; cfg_writes = 0; cycles = 0;
    calm = 1'b0; hold_req = 0;
    cur_width = 256; cur_scale = 2560;
    foreach (col_written[i]) begin
      col_written[i] = 1'b0;
      line_mirror[i] = '0;
    end
    rst_n <= 1'b0;
    cfg_we <= 1'b0; cfg_index <= REG_IMAGE_WIDTH; cfg_wdata <= '0;
    in_ch.valid <= 1'b0; in_ch.pixel_col <= '0; in_ch.pixel_row <= '0;
    in_ch.height_sample <= '0; in_ch.specular_sample <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_extremes();
    test_zero_norm();
    test_backpressure();
    test_random_frames();
    drain();

    if (normal_q.size() != 0) errors++;
    $display("covered %0d pixel words, %0d normal words checked, %0d register writes",
             words_sent, words_checked, cfg_writes);
    $display("widths 0..2047 incl. saturation, scales 0..65535, zero norm and stalls");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
